### src/mpsd_pkg.sv
// ----------------------------------------------------------------------------
// mpsd_pkg
// Shared types and constants for the program stream demultiplexer.
// ----------------------------------------------------------------------------
`default_nettype none

package mpsd_pkg;

    // Stream ids with a fixed meaning
    localparam logic [7:0] ID_PACK  = 8'hBA;
    localparam logic [7:0] ID_SYS   = 8'hBB;
    localparam logic [7:0] ID_PRIV1 = 8'hBD;
    localparam logic [7:0] ID_PAD   = 8'hBE;
    localparam logic [7:0] ID_PRIV2 = 8'hBF;

    // Configuration register indexes
    localparam int          CFG_IDX_W    = 2;
    localparam logic [1:0]  CFG_VIDEO_ID = 2'd0;
    localparam logic [1:0]  CFG_AUDIO_ID = 2'd1;
    localparam logic [7:0]  VIDEO_ID_RST = 8'hE0;
    localparam logic [7:0]  AUDIO_ID_RST = 8'hC0;

    // Start code hunt
    localparam logic [1:0] SYNC_NONE  = 2'd0;
    localparam logic [1:0] SYNC_ZERO1 = 2'd1;
    localparam logic [1:0] SYNC_ZERO2 = 2'd2;

    // Format codes
    localparam logic [1:0] FMT_UNKNOWN = 2'd0;
    localparam logic [1:0] FMT_MPEG1   = 2'd1;
    localparam logic [1:0] FMT_MPEG2   = 2'd2;

    // Pack header byte counts
    localparam logic [15:0] PACK1_SKIP = 16'd7;
    localparam logic [15:0] PACK2_SKIP = 16'd8;

    // Audio probe window
    localparam logic [3:0] PROBE_LEN = 4'd14;

    // Packet header replay: six bytes, index of the last one
    localparam logic [2:0] HDR_LAST = 3'd5;

    // Command queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        PH_SCAN  = 3'd0,
        PH_ID    = 3'd1,
        PH_PACK2 = 3'd2,
        PH_LEN   = 3'd3,
        PH_SKIP  = 3'd4,
        PH_PASS  = 3'd5,
        PH_PACK0 = 3'd6
    } phase_t;

    // One command from parser to output sequencer
    typedef struct packed {
        logic       is_hdr;   // replay 00 00 01 id lenH lenL
        logic [7:0] data;     // payload byte, or low length byte
        logic [7:0] id;
        logic [7:0] len_hi;
        logic       ch;
        logic [1:0] pfmt;
        logic [1:0] afmt;
    } cmd_t;

endpackage

`default_nettype wire

### src/mpsd_front.sv
// ----------------------------------------------------------------------------
// mpsd_front
// Byte parser: start code hunt, stream id decode, header skipping and
// audio format probe. Emits one command per byte that produces output.
// ----------------------------------------------------------------------------
`default_nettype none

module mpsd_front import mpsd_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire logic                 in_take,
    input  wire logic [7:0]           in_byte,
    output logic                      push,
    output cmd_t                      cmd
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  sync_reg, sync_next;
    logic [7:0]  cur_id_reg, cur_id_next;
    logic        hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] left_reg, left_next;
    logic [3:0]  probe_cnt_reg, probe_cnt_next;
    logic        probe_done_reg, probe_done_next;
    logic [1:0]  pack_fmt_reg, pack_fmt_next;
    logic [1:0]  audio_kind_reg, audio_kind_next;
    logic [7:0]  video_id_reg, audio_id_reg;

    logic        id_passed, cur_passed, cur_ch;

    assign cfg_ready  = 1'b1;
    assign id_passed  = (in_byte == video_id_reg) || (in_byte == audio_id_reg);
    assign cur_passed = (cur_id_reg == video_id_reg) || (cur_id_reg == audio_id_reg);
    assign cur_ch     = (cur_id_reg != video_id_reg);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            video_id_reg <= VIDEO_ID_RST;
            audio_id_reg <= AUDIO_ID_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_VIDEO_ID) video_id_reg <= cfg_data;
            if (cfg_index == CFG_AUDIO_ID) audio_id_reg <= cfg_data;
        end
    end

    // Next state
    always_comb begin
        phase_next      = phase_reg;
        sync_next       = sync_reg;
        cur_id_next     = cur_id_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        len_hi_next     = len_hi_reg;
        left_next       = left_reg;
        probe_cnt_next  = probe_cnt_reg;
        probe_done_next = probe_done_reg;
        pack_fmt_next   = pack_fmt_reg;
        audio_kind_next = audio_kind_reg;
        case (phase_reg)
            PH_ID: begin
                cur_id_next     = in_byte;
                sync_next       = SYNC_NONE;
                hdr_cnt_next    = 1'b0;
                probe_cnt_next  = '0;
                probe_done_next = 1'b0;
                if (id_passed) begin
                    phase_next = PH_LEN;
                end else if (in_byte == ID_PACK) begin
                    phase_next = PH_PACK0;
                end else if (in_byte == ID_SYS || in_byte == ID_PRIV1 ||
                             in_byte == ID_PAD || in_byte == ID_PRIV2) begin
                    phase_next = PH_LEN;
                end else begin
                    phase_next = PH_SCAN;
                end
            end
            PH_PACK0: begin
                if (in_byte[7:4] == 4'h2) begin
                    pack_fmt_next = FMT_MPEG1;
                    left_next     = PACK1_SKIP;
                    phase_next    = PH_SKIP;
                end else if (in_byte[7:6] == 2'b01) begin
                    pack_fmt_next = FMT_MPEG2;
                    left_next     = PACK2_SKIP;
                    phase_next    = PH_PACK2;
                end else begin
                    phase_next = PH_SCAN;
                    sync_next  = SYNC_NONE;
                end
            end
            PH_PACK2: begin
                if (left_reg != '0) begin
                    left_next = left_reg - 16'd1;
                end else begin
                    // stuffing length in the low three bits
                    left_next = {13'd0, in_byte[2:0]};
                    if (in_byte[2:0] != 3'd0) begin
                        phase_next = PH_SKIP;
                    end else begin
                        phase_next = PH_SCAN;
                        sync_next  = SYNC_NONE;
                    end
                end
            end
            PH_LEN: begin
                if (!hdr_cnt_reg) begin
                    len_hi_next  = in_byte;
                    hdr_cnt_next = 1'b1;
                end else begin
                    hdr_cnt_next = 1'b0;
                    left_next    = {len_hi_reg, in_byte};
                    if ({len_hi_reg, in_byte} != 16'd0) begin
                        phase_next = cur_passed ? PH_PASS : PH_SKIP;
                    end else begin
                        phase_next = PH_SCAN;
                        sync_next  = SYNC_NONE;
                    end
                end
            end
            PH_SKIP, PH_PASS: begin
                if (phase_reg == PH_PASS && cur_ch && !probe_done_reg) begin
                    if (in_byte != 8'hFF) begin
                        probe_done_next = 1'b1;
                        if (in_byte[7:6] == 2'b10)      audio_kind_next = FMT_MPEG2;
                        else if (in_byte[7:6] == 2'b01) audio_kind_next = FMT_MPEG1;
                    end else begin
                        probe_cnt_next = probe_cnt_reg + 4'd1;
                        if (probe_cnt_next >= PROBE_LEN) probe_done_next = 1'b1;
                    end
                end
                if (left_reg > 16'd1) begin
                    left_next = left_reg - 16'd1;
                end else begin
                    left_next  = '0;
                    phase_next = PH_SCAN;
                    sync_next  = SYNC_NONE;
                end
            end
            default: begin
                // start code hunt; zero runs of any length allowed
                phase_next = PH_SCAN;
                if (sync_reg == SYNC_ZERO1) begin
                    sync_next = (in_byte == 8'h00) ? SYNC_ZERO2 : SYNC_NONE;
                end else if (sync_reg == SYNC_ZERO2) begin
                    if (in_byte == 8'h01)      phase_next = PH_ID;
                    else if (in_byte != 8'h00) sync_next  = SYNC_NONE;
                end else begin
                    sync_next = (in_byte == 8'h00) ? SYNC_ZERO1 : SYNC_NONE;
                end
            end
        endcase
    end

    // Command outputs
    always_comb begin
        push = in_take && ((phase_reg == PH_LEN && hdr_cnt_reg && cur_passed) ||
                           phase_reg == PH_PASS);
        cmd.is_hdr = (phase_reg == PH_LEN);
        cmd.data   = in_byte;
        cmd.id     = cur_id_reg;
        cmd.len_hi = len_hi_reg;
        cmd.ch     = cur_ch;
        cmd.pfmt   = pack_fmt_next;
        cmd.afmt   = audio_kind_next;
    end

    // Parser state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SCAN;
            sync_reg       <= SYNC_NONE;
            cur_id_reg     <= '0;
            hdr_cnt_reg    <= 1'b0;
            len_hi_reg     <= '0;
            left_reg       <= '0;
            probe_cnt_reg  <= '0;
            probe_done_reg <= 1'b0;
            pack_fmt_reg   <= FMT_UNKNOWN;
            audio_kind_reg <= FMT_UNKNOWN;
        end else if (in_take) begin
            phase_reg      <= phase_next;
            sync_reg       <= sync_next;
            cur_id_reg     <= cur_id_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            len_hi_reg     <= len_hi_next;
            left_reg       <= left_next;
            probe_cnt_reg  <= probe_cnt_next;
            probe_done_reg <= probe_done_next;
            pack_fmt_reg   <= pack_fmt_next;
            audio_kind_reg <= audio_kind_next;
        end
    end

endmodule

`default_nettype wire

### src/mpsd_queue.sv
// ----------------------------------------------------------------------------
// mpsd_queue
// Small command FIFO between parser and output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mpsd_queue import mpsd_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      empty,
    output cmd_t      head
);

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop)      count_next = count_reg + (QPTR_W+1)'(1);
        else if (!push && pop) count_next = count_reg - (QPTR_W+1)'(1);
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_cmd;
    end

    // Pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

### src/mpsd_back.sv
// ----------------------------------------------------------------------------
// mpsd_back
// Output sequencer: expands queued commands into result bytes and holds
// them in an output register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mpsd_back import mpsd_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  empty,
    input  wire cmd_t  head,
    output logic       pop,
    output logic       m_valid,
    input  wire logic  m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_channel,
    output logic       m_last,
    output logic [1:0] m_program_format,
    output logic [1:0] m_audio_format
);

    logic       valid_reg, valid_next;
    logic [2:0] idx_reg, idx_next;
    logic [7:0] byte_reg, byte_next;
    logic       ch_reg, last_reg, last_next;
    logic [1:0] pfmt_reg, afmt_reg;
    logic       load, take;

    assign load = !valid_reg || m_ready;
    assign take = load && !empty;

    // Header byte select and sequencing
    always_comb begin
        case (idx_reg)
            3'd0, 3'd1: byte_next = 8'h00;
            3'd2:       byte_next = 8'h01;
            3'd3:       byte_next = head.id;
            3'd4:       byte_next = head.len_hi;
            default:    byte_next = head.data;
        endcase
        if (!head.is_hdr) byte_next = head.data;
        last_next  = !head.is_hdr || (idx_reg == HDR_LAST);
        pop        = take && last_next;
        idx_next   = idx_reg;
        if (take) idx_next = last_next ? 3'd0 : idx_reg + 3'd1;
        valid_next = load ? !empty : valid_reg;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (take) begin
            byte_reg <= byte_next;
            ch_reg   <= head.ch;
            last_reg <= last_next;
            pfmt_reg <= head.pfmt;
            afmt_reg <= head.afmt;
        end
    end

    assign m_valid          = valid_reg;
    assign m_out_byte       = byte_reg;
    assign m_out_channel    = ch_reg;
    assign m_last           = last_reg;
    assign m_program_format = pfmt_reg;
    assign m_audio_format   = afmt_reg;

endmodule

`default_nettype wire

### src/mpeg_program_stream_demux_core.sv
// ----------------------------------------------------------------------------
// mpeg_program_stream_demux_core
// MPEG program stream demultiplexer: passes video and audio packets whole,
// skips pack headers and other streams.
// ----------------------------------------------------------------------------
//  channel | ports                                   | role
//  --------+-----------------------------------------+---------------------
//  s_      | s_valid s_ready s_in_byte               | stream bytes in
//  m_      | m_valid m_ready m_out_byte ...          | packet bytes out
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data  | id register writes
//
//  One byte is taken per cycle while the 4-entry command queue has room.
//  The second length byte of a passed packet makes a six-byte header
//  request, drained one byte per cycle by the output sequencer while m_ready
//  is high; payload bytes give one result each. The output sequencer sets the
//  peak rate. Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module mpeg_program_stream_demux_core import mpsd_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_in_byte,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [7:0]                m_out_byte,
    output logic                      m_out_channel,
    output logic                      m_last,
    output logic [1:0]                m_program_format,
    output logic [1:0]                m_audio_format
);

    logic full, empty, push, pop, in_take;
    cmd_t cmd, head;

    assign s_ready = !full;
    assign in_take = s_valid && s_ready;

    // Parser
    mpsd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_take   (in_take),
        .in_byte   (s_in_byte),
        .push      (push),
        .cmd       (cmd)
    );

    // Command queue
    mpsd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (cmd),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    // Output sequencer
    mpsd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .empty            (empty),
        .head             (head),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_out_channel    (m_out_channel),
        .m_last           (m_last),
        .m_program_format (m_program_format),
        .m_audio_format   (m_audio_format)
    );

endmodule

`default_nettype wire

### tb/sv/tb_mpeg_program_stream_demux_core.sv
// ----------------------------------------------------------------------------
// tb_mpeg_program_stream_demux_core
// Self-checking bench for the program stream demultiplexer. A byte-level
// model of the parser tracks every accepted stream byte and queues the packet
// bytes it should pass out; each output request is checked field by field
// against the oldest queued byte. Stimulus is a short hand-built stream, then
// well-formed random packs and packets mixed with noise, under several
// stream id settings and handshake idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mpeg_program_stream_demux_core;
    import mpsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] PROGRAM_END_ID = 8'hB9;
    localparam int         SETTLE_CYCLES  = 12;
    localparam int         MAX_REPORTS    = 10;

    // One expected packet byte on the output channel
    typedef struct {
        logic [7:0] data;
        logic       ch;
        logic       last;
        logic [1:0] pfmt;
        logic [1:0] afmt;
    } pkt_byte_t;

    // Parser model plus queue of packet bytes still owed by the block
    class pes_scoreboard;
        logic [7:0]  video_id;
        logic [7:0]  audio_id;
        phase_t      parse_st;
        logic [1:0]  sync_st;
        logic [7:0]  cur_id;
        logic        len_seen;
        logic [7:0]  len_hi;
        logic [15:0] left;
        logic [3:0]  probe_cnt;
        logic        probe_done;
        logic [1:0]  pack_fmt;
        logic [1:0]  audio_fmt;
        pkt_byte_t   expected_bytes[$];
        int          errors;

        function new();
            video_id   = VIDEO_ID_RST;
            audio_id   = AUDIO_ID_RST;
            parse_st   = PH_SCAN;
            sync_st    = SYNC_NONE;
            cur_id     = 8'h00;
            len_seen   = 1'b0;
            len_hi     = 8'h00;
            left       = 16'd0;
            probe_cnt  = 4'd0;
            probe_done = 1'b0;
            pack_fmt   = FMT_UNKNOWN;
            audio_fmt  = FMT_UNKNOWN;
            errors     = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void write_id(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
            if (idx == CFG_VIDEO_ID) begin
                video_id = data;
            end else if (idx == CFG_AUDIO_ID) begin
                audio_id = data;
            end
        endfunction

        function void owe(logic [7:0] data, logic ch, logic lst);
            pkt_byte_t pb;
            pb.data = data;
            pb.ch   = ch;
            pb.last = lst;
            pb.pfmt = pack_fmt;
            pb.afmt = audio_fmt;
            expected_bytes.push_back(pb);
        endfunction

        function void rescan();
            parse_st = PH_SCAN;
            sync_st  = SYNC_NONE;
        endfunction

        function logic passed_id(logic [7:0] id);
            return (id == video_id) || (id == audio_id);
        endfunction

        // Advance the parser by one accepted stream byte
        function void take_stream_byte(logic [7:0] b);
            logic ch;
            ch = (cur_id == video_id) ? 1'b0 : 1'b1;
            case (parse_st)
                PH_ID: begin
                    cur_id     = b;
                    sync_st    = SYNC_NONE;
                    len_seen   = 1'b0;
                    probe_cnt  = 4'd0;
                    probe_done = 1'b0;
                    if (passed_id(b)) begin
                        parse_st = PH_LEN;
                    end else if (b == ID_PACK) begin
                        parse_st = PH_PACK0;
                    end else if (b == ID_SYS || b == ID_PRIV1 || b == ID_PAD ||
                                 b == ID_PRIV2) begin
                        parse_st = PH_LEN;
                    end else begin
                        rescan();
                    end
                end
                PH_PACK0: begin
                    if (b[7:4] == 4'h2) begin
                        pack_fmt = FMT_MPEG1;
                        left     = PACK1_SKIP;
                        parse_st = PH_SKIP;
                    end else if (b[7:6] == 2'b01) begin
                        pack_fmt = FMT_MPEG2;
                        left     = PACK2_SKIP;
                        parse_st = PH_PACK2;
                    end else begin
                        rescan();
                    end
                end
                PH_PACK2: begin
                    if (left != 16'd0) begin
                        left = left - 16'd1;
                    end else begin
                        // stuffing count sits in the low bits of the last byte
                        left = {13'd0, b[2:0]};
                        if (left != 16'd0) parse_st = PH_SKIP;
                        else rescan();
                    end
                end
                PH_LEN: begin
                    if (!len_seen) begin
                        len_hi   = b;
                        len_seen = 1'b1;
                    end else begin
                        len_seen = 1'b0;
                        left     = {len_hi, b};
                        if (passed_id(cur_id)) begin
                            owe(8'h00, ch, 1'b0);
                            owe(8'h00, ch, 1'b0);
                            owe(8'h01, ch, 1'b0);
                            owe(cur_id, ch, 1'b0);
                            owe(len_hi, ch, 1'b0);
                            owe(b, ch, 1'b1);
                            if (left != 16'd0) parse_st = PH_PASS;
                            else rescan();
                        end else begin
                            if (left != 16'd0) parse_st = PH_SKIP;
                            else rescan();
                        end
                    end
                end
                PH_SKIP: begin
                    if (left > 16'd1) begin
                        left = left - 16'd1;
                    end else begin
                        left = 16'd0;
                        rescan();
                    end
                end
                PH_PASS: begin
                    // audio format probe over the leading payload bytes
                    if (ch && !probe_done) begin
                        if (b != 8'hFF) begin
                            probe_done = 1'b1;
                            if (b[7:6] == 2'b10) audio_fmt = FMT_MPEG2;
                            else if (b[7:6] == 2'b01) audio_fmt = FMT_MPEG1;
                        end else begin
                            probe_cnt = probe_cnt + 4'd1;
                            if (probe_cnt >= PROBE_LEN) probe_done = 1'b1;
                        end
                    end
                    owe(b, ch, 1'b1);
                    if (left > 16'd1) begin
                        left = left - 16'd1;
                    end else begin
                        left = 16'd0;
                        rescan();
                    end
                end
                default: begin
                    // start code hunt: a run of two or more zeros, then 01
                    parse_st = PH_SCAN;
                    if (sync_st == SYNC_ZERO1) begin
                        sync_st = (b == 8'h00) ? SYNC_ZERO2 : SYNC_NONE;
                    end else if (sync_st == SYNC_ZERO2) begin
                        if (b == 8'h01) parse_st = PH_ID;
                        else if (b != 8'h00) sync_st = SYNC_NONE;
                    end else begin
                        sync_st = (b == 8'h00) ? SYNC_ZERO1 : SYNC_NONE;
                    end
                end
            endcase
        endfunction

        // Compare one output request with the oldest owed byte
        function void check_out_byte(logic [7:0] data, logic ch, logic lst,
                                     logic [1:0] pf, logic [1:0] af);
            pkt_byte_t pb;
            if (expected_bytes.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected output: byte %h ch %0d last %0d pf %0d af %0d",
                             data, ch, lst, pf, af);
                return;
            end
            pb = expected_bytes.pop_front();
            if (data !== pb.data || ch !== pb.ch || lst !== pb.last ||
                pf !== pb.pfmt || af !== pb.afmt) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("output mismatch: exp %h/%0d/%0d/%0d/%0d got %h/%0d/%0d/%0d/%0d",
                             pb.data, pb.ch, pb.last, pb.pfmt, pb.afmt,
                             data, ch, lst, pf, af);
            end
        endfunction
    endclass

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = CFG_VIDEO_ID;
    logic [7:0]           cfg_data      = 8'h00;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_in_byte     = 8'h00;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [7:0]           m_out_byte;
    logic                 m_out_channel;
    logic                 m_last;
    logic [1:0]           m_program_format;
    logic [1:0]           m_audio_format;

    pes_scoreboard sb;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    logic [7:0]    cur_video_id  = VIDEO_ID_RST;
    logic [7:0]    cur_audio_id  = AUDIO_ID_RST;
    int            phase_bytes   = 0;

    mpeg_program_stream_demux_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_in_byte        (s_in_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_out_channel    (m_out_channel),
        .m_last           (m_last),
        .m_program_format (m_program_format),
        .m_audio_format   (m_audio_format)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Receiver stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Handshake monitor: register writes, stream bytes, output requests
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_id(cfg_index, cfg_data);
            if (s_valid && s_ready) sb.take_stream_byte(s_in_byte);
            if (m_valid && m_ready)
                sb.check_out_byte(m_out_byte, m_out_channel, m_last,
                                  m_program_format, m_audio_format);
        end
    end

    // Run limit
    initial begin
        #400000;
        $display("tb_mpeg_program_stream_demux_core NOT OK");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!(s_valid && s_ready));
        phase_bytes++;
    endtask

    task automatic send_list(input logic [7:0] bytes[$]);
        foreach (bytes[i]) send_byte(bytes[i]);
    endtask

    // Pause the stream until every owed byte is out, then let the block settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_ids(input logic [7:0] vid, input logic [7:0] aid);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_VIDEO_ID;
        cfg_data  <= vid;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_index <= CFG_AUDIO_ID;
        cfg_data  <= aid;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid    <= 1'b0;
        cur_video_id = vid;
        cur_audio_id = aid;
    endtask

    task automatic send_start_code();
        int zeros;
        zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 5) : 2;
        repeat (zeros) send_byte(8'h00);
        send_byte(8'h01);
    endtask

    // Packet with a length field; audio-style payload leads with 0xFF fill
    task automatic send_packet(input logic [7:0] id, input logic [15:0] len,
                               input bit audio_style);
        int         nff;
        int         kind;
        logic [7:0] b;
        nff  = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 15) : $urandom_range(0, 2);
        kind = $urandom_range(0, 2);
        send_start_code();
        send_byte(id);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        for (int i = 0; i < int'(len); i++) begin
            b = 8'($urandom_range(0, 255));
            if (audio_style && i < nff) begin
                b = 8'hFF;
            end else if (audio_style && i == nff) begin
                if (kind == 0) b[7:6] = 2'b10;
                else if (kind == 1) b[7:6] = 2'b01;
                else b[7:6] = $urandom_range(0, 1) ? 2'b11 : 2'b00;
            end
            send_byte(b);
        end
    endtask

    function automatic logic [15:0] pick_len();
        if ($urandom_range(0, 7) == 0) return 16'd0;
        return 16'($urandom_range(1, 12));
    endfunction

    // One random stream unit: mostly well-formed, some broken, some noise
    task automatic send_random_unit();
        int         r;
        int         stuff;
        logic [7:0] b;
        logic [7:0] skip_ids[4];
        skip_ids = '{ID_SYS, ID_PRIV1, ID_PAD, ID_PRIV2};
        r = $urandom_range(0, 99);
        if (r < 28) begin
            send_packet(cur_video_id, pick_len(), 1'b0);
        end else if (r < 52) begin
            send_packet(cur_audio_id, pick_len(), 1'b1);
        end else if (r < 62) begin
            // MPEG-1 pack header
            send_start_code();
            send_byte(ID_PACK);
            b = 8'($urandom_range(0, 255));
            b[7:4] = 4'h2;
            send_byte(b);
            repeat (7) send_byte(8'($urandom_range(0, 255)));
        end else if (r < 72) begin
            // MPEG-2 pack header with stuffing
            send_start_code();
            send_byte(ID_PACK);
            b = 8'($urandom_range(0, 255));
            b[7:6] = 2'b01;
            send_byte(b);
            repeat (8) send_byte(8'($urandom_range(0, 255)));
            b = 8'($urandom_range(0, 255));
            stuff = b[2:0];
            send_byte(b);
            repeat (stuff) send_byte(8'hFF);
        end else if (r < 82) begin
            send_start_code();
            send_byte(skip_ids[$urandom_range(0, 3)]);
            b = 8'($urandom_range(0, 6));
            send_byte(8'h00);
            send_byte(b);
            repeat (int'(b)) send_byte(8'($urandom_range(0, 255)));
        end else if (r < 87) begin
            // pack id followed by an invalid first byte
            send_start_code();
            send_byte(ID_PACK);
            do b = 8'($urandom_range(0, 255));
            while (b[7:4] == 4'h2 || b[7:6] == 2'b01);
            send_byte(b);
        end else if (r < 93) begin
            send_start_code();
            send_byte($urandom_range(0, 1) ? PROGRAM_END_ID : 8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random_phase(input int n_bytes, input bit pause_midway);
        bit paused;
        paused      = 1'b0;
        phase_bytes = 0;
        while (phase_bytes < n_bytes) begin
            send_random_unit();
            if (pause_midway && !paused && phase_bytes >= n_bytes / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    task automatic set_idling(input int snd, input int rcv);
        send_idle_pct = snd;
        recv_idle_pct = rcv;
    endtask

    initial begin
        logic [7:0] same_id;
        sb = new();
        set_idling(6, 47);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_ids(VIDEO_ID_RST, AUDIO_ID_RST);

        // zero run before the start code, video packet with extreme payload
        send_list('{8'h00, 8'h00, 8'h00, 8'h01, 8'hE0, 8'h00, 8'h02, 8'h00, 8'hFF});
        // audio packet: fill byte, then MPEG-2 audio marker
        send_list('{8'h00, 8'h00, 8'h01, 8'hC0, 8'h00, 8'h02, 8'hFF, 8'h85});
        // zero-length video packet, program end
        send_list('{8'h00, 8'h00, 8'h01, 8'hE0, 8'h00, 8'h00});
        send_list('{8'h00, 8'h00, 8'h01, PROGRAM_END_ID});
        // video packet left open across an id change
        send_list('{8'h00, 8'h00, 8'h01, 8'hE0, 8'h00, 8'h04, 8'h11, 8'h22});
        wait_drained();
        set_ids(8'h00, 8'hFF);
        send_list('{8'h33, 8'h44});
        run_random_phase(25, 1'b0);
        wait_drained();

        // configured ids override the fixed meanings of private and pack ids
        set_idling(47, 6);
        set_ids(ID_PRIV1, ID_PACK);
        run_random_phase(25, 1'b1);
        wait_drained();

        // both channels on one id: video wins
        same_id = 8'($urandom_range(0, 255));
        set_ids(same_id, same_id);
        run_random_phase(15, 1'b0);
        wait_drained();

        set_idling(0, 0);
        set_ids(VIDEO_ID_RST, AUDIO_ID_RST);
        run_random_phase(20, 1'b0);
        // long video packet left open at the end: nonzero high length byte
        send_start_code();
        send_byte(cur_video_id);
        send_byte(8'h01);
        send_byte(8'($urandom_range(0, 255)));
        repeat (6) send_byte(8'($urandom_range(0, 255)));

        wait_drained();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_mpeg_program_stream_demux_core OK");
        end else begin
            $display("tb_mpeg_program_stream_demux_core NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
